FILE: rtl/qmml_pkg.sv
// ----------------------------------------------------------------------------
// qmml_pkg
// Shared types and constants for the plus-frame motor mixer and limiter.
// ----------------------------------------------------------------------------
package qmml_pkg;

	// Field widths
	localparam int PULSE_W  = 12;	// motor pulse width and config levels
	localparam int THR_W    = 13;	// signed throttle
	localparam int CMD_W    = 12;	// signed roll, pitch, yaw
	localparam int MIX_W    = 15;	// signed raw mix: idle +/- two commands
	localparam int TRIM_W   = 14;	// signed adjusted throttle
	localparam int SUM_W    = 15;	// signed motor plus adjusted throttle
	localparam int NUM_MOT  = 4;

	localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

	// Motor slots, in output order
	localparam int MOT_FRONT = 0;
	localparam int MOT_LEFT  = 1;
	localparam int MOT_BACK  = 2;
	localparam int MOT_RIGHT = 3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd2;

	// Reset values of the levels
	localparam logic [PULSE_W-1:0] IDLE_RST    = 12'd1100;
	localparam logic [PULSE_W-1:0] FLOOR_RST   = 12'd1000;
	localparam logic [PULSE_W-1:0] CEILING_RST = 12'd2000;

	typedef logic signed [MIX_W-1:0]  mix_word_t;
	typedef logic        [PULSE_W-1:0] pulse_t;
	typedef logic signed [THR_W-1:0]  thr_t;
	typedef logic signed [TRIM_W-1:0] trim_t;

	// Raw mix out of the first stage
	typedef struct packed {
		mix_word_t [NUM_MOT-1:0] mot;
		thr_t                    thr;
	} mix_t;

	// Clamped motors with their spread
	typedef struct packed {
		pulse_t [NUM_MOT-1:0] mot;
		pulse_t               lo;
		pulse_t               hi;
		thr_t                 thr;
	} lim_t;

	// Level set used by the stages
	typedef struct packed {
		pulse_t idle;
		pulse_t floor_lvl;
		pulse_t ceil_lvl;
	} levels_t;

endpackage

FILE: rtl/qmml_mix.sv
// ----------------------------------------------------------------------------
// qmml_mix
// Stage 1: mix throttle, roll, pitch and yaw around the idle level.
// ----------------------------------------------------------------------------
module qmml_mix import qmml_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	output logic                     in_rdy,
	input  logic signed [THR_W-1:0]  throttle,
	input  logic signed [CMD_W-1:0]  roll,
	input  logic signed [CMD_W-1:0]  pitch,
	input  logic signed [CMD_W-1:0]  yaw,
	input  pulse_t                   idle,
	output logic                     out_vld,
	input  logic                     out_rdy,
	output mix_t                     out_data
);

	logic      valid_s1;
	mix_t      data_s1;
	mix_t      mix_d;
	mix_word_t idle_w, roll_w, pitch_w, yaw_w;

	// Take a new command when the stage is empty or drains this cycle
	assign in_rdy = !valid_s1 || out_rdy;

	// Widen operands to the mix width
	assign idle_w  = mix_word_t'({{(MIX_W-PULSE_W){1'b0}}, idle});
	assign roll_w  = mix_word_t'({{(MIX_W-CMD_W){roll[CMD_W-1]}}, roll});
	assign pitch_w = mix_word_t'({{(MIX_W-CMD_W){pitch[CMD_W-1]}}, pitch});
	assign yaw_w   = mix_word_t'({{(MIX_W-CMD_W){yaw[CMD_W-1]}}, yaw});

	// Plus-frame mix: opposing motors take opposite pitch or roll
	always_comb begin
		mix_d.mot[MOT_FRONT] = idle_w + pitch_w - yaw_w;
		mix_d.mot[MOT_LEFT]  = idle_w + roll_w + yaw_w;
		mix_d.mot[MOT_BACK]  = idle_w - pitch_w - yaw_w;
		mix_d.mot[MOT_RIGHT] = idle_w - roll_w + yaw_w;
		mix_d.thr            = throttle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_rdy) begin
			valid_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			data_s1 <= mix_d;
		end
	end

	assign out_vld  = valid_s1;
	assign out_data = data_s1;

endmodule

FILE: rtl/qmml_limit.sv
// ----------------------------------------------------------------------------
// qmml_limit
// Stages 2 and 3: clamp each motor to the floor and ceiling, then find the
// lowest and highest clamped motor.
// ----------------------------------------------------------------------------
module qmml_limit import qmml_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_vld,
	output logic    in_rdy,
	input  mix_t    in_data,
	input  pulse_t  floor_lvl,
	input  pulse_t  ceil_lvl,
	output logic    out_vld,
	input  logic    out_rdy,
	output lim_t    out_data
);

	logic      valid_s2, valid_s3;
	logic      rdy_s2, rdy_s3;
	lim_t      data_s2, data_s3;
	lim_t      clamp_d, span_d;
	mix_word_t floor_w, ceil_w;
	pulse_t    lo_a, lo_b, hi_a, hi_b;

	assign rdy_s3 = !valid_s3 || out_rdy;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign in_rdy = rdy_s2;

	assign floor_w = mix_word_t'({{(MIX_W-PULSE_W){1'b0}}, floor_lvl});
	assign ceil_w  = mix_word_t'({{(MIX_W-PULSE_W){1'b0}}, ceil_lvl});

	// Clamp: floor test wins over ceiling test
	always_comb begin
		clamp_d = '0;
		for (int i = 0; i < NUM_MOT; i++) begin
			if (in_data.mot[i] < floor_w) begin
				clamp_d.mot[i] = floor_lvl;
			end else if (in_data.mot[i] > ceil_w) begin
				clamp_d.mot[i] = ceil_lvl;
			end else begin
				clamp_d.mot[i] = in_data.mot[i][PULSE_W-1:0];
			end
		end
		clamp_d.thr = in_data.thr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_vld) begin
			data_s2 <= clamp_d;
		end
	end

	// Two-level min/max tree over the clamped motors
	always_comb begin
		lo_a = (data_s2.mot[0] < data_s2.mot[1]) ? data_s2.mot[0] : data_s2.mot[1];
		lo_b = (data_s2.mot[2] < data_s2.mot[3]) ? data_s2.mot[2] : data_s2.mot[3];
		hi_a = (data_s2.mot[0] > data_s2.mot[1]) ? data_s2.mot[0] : data_s2.mot[1];
		hi_b = (data_s2.mot[2] > data_s2.mot[3]) ? data_s2.mot[2] : data_s2.mot[3];
		span_d     = data_s2;
		span_d.lo  = (lo_a < lo_b) ? lo_a : lo_b;
		span_d.hi  = (hi_a > hi_b) ? hi_a : hi_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			data_s3 <= span_d;
		end
	end

	assign out_vld  = valid_s3;
	assign out_data = data_s3;

	// Spread is ordered; front and left sit at or above lo, back and right at or below hi
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (data_s3.lo <= data_s3.hi))
		else $error("qmml_limit: lowest motor above highest");

	a_span_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (data_s3.mot[MOT_FRONT] >= data_s3.lo &&
		data_s3.mot[MOT_LEFT] >= data_s3.lo && data_s3.mot[MOT_BACK] <= data_s3.hi &&
		data_s3.mot[MOT_RIGHT] <= data_s3.hi))
		else $error("qmml_limit: motor outside its spread");

endmodule

FILE: rtl/qmml_trim.sv
// ----------------------------------------------------------------------------
// qmml_trim
// Stages 4 and 5: pull the throttle into range, then add it to every motor
// and saturate into the output register.
// ----------------------------------------------------------------------------
module qmml_trim import qmml_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_vld,
	output logic    in_rdy,
	input  lim_t    in_data,
	input  pulse_t  floor_lvl,
	input  pulse_t  ceil_lvl,
	output logic    out_vld,
	input  logic    out_rdy,
	output pulse_t  front_drive,
	output pulse_t  left_drive,
	output pulse_t  back_drive,
	output pulse_t  right_drive
);

	logic                     valid_s4, valid_s5;
	logic                     rdy_s4, rdy_s5;
	pulse_t [NUM_MOT-1:0]     mot_s4;
	trim_t                    thr_s4;
	pulse_t [NUM_MOT-1:0]     drive_s5;
	pulse_t [NUM_MOT-1:0]     drive_d;
	trim_t                    thr_w, lo_w, hi_w, floor_t, ceil_t, thr_d;
	logic signed [SUM_W-1:0]  sum;

	assign rdy_s5 = !valid_s5 || out_rdy;
	assign rdy_s4 = !valid_s4 || rdy_s5;
	assign in_rdy = rdy_s4;

	assign thr_w   = trim_t'({{(TRIM_W-THR_W){in_data.thr[THR_W-1]}}, in_data.thr});
	assign lo_w    = trim_t'({{(TRIM_W-PULSE_W){1'b0}}, in_data.lo});
	assign hi_w    = trim_t'({{(TRIM_W-PULSE_W){1'b0}}, in_data.hi});
	assign floor_t = trim_t'({{(TRIM_W-PULSE_W){1'b0}}, floor_lvl});
	assign ceil_t  = trim_t'({{(TRIM_W-PULSE_W){1'b0}}, ceil_lvl});

	// Throttle: lift to floor first, else pull down to ceiling
	always_comb begin
		if (lo_w + thr_w < floor_t) begin
			thr_d = floor_t - lo_w;
		end else if (hi_w + thr_w > ceil_t) begin
			thr_d = ceil_t - hi_w;
		end else begin
			thr_d = thr_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy_s4) begin
			valid_s4 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_vld) begin
			mot_s4 <= in_data.mot;
			thr_s4 <= thr_d;
		end
	end

	// Add throttle to each motor and saturate to the pulse range
	always_comb begin
		drive_d = '0;
		sum     = '0;
		for (int i = 0; i < NUM_MOT; i++) begin
			sum = $signed({{(SUM_W-PULSE_W){1'b0}}, mot_s4[i]}) +
				$signed({{(SUM_W-TRIM_W){thr_s4[TRIM_W-1]}}, thr_s4});
			if (sum < 0) begin
				drive_d[i] = '0;
			end else if (sum > $signed({{(SUM_W-PULSE_W){1'b0}}, PULSE_MAX})) begin
				drive_d[i] = PULSE_MAX;
			end else begin
				drive_d[i] = sum[PULSE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (rdy_s5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && valid_s4) begin
			drive_s5 <= drive_d;
		end
	end

	assign out_vld     = valid_s5;
	assign front_drive = drive_s5[MOT_FRONT];
	assign left_drive  = drive_s5[MOT_LEFT];
	assign back_drive  = drive_s5[MOT_BACK];
	assign right_drive = drive_s5[MOT_RIGHT];

	// Stage 4, blocked by a full output stage, holds its item
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !rdy_s5) |=> (valid_s4 && $stable(thr_s4) && $stable(mot_s4)))
		else $error("qmml_trim: stalled stage 4 item changed");

	// A result taken with stage 4 empty leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && out_rdy && !valid_s4) |=> !valid_s5)
		else $error("qmml_trim: result repeated after transfer");

endmodule

FILE: rtl/quad_motor_mix_limiter_top.sv
// ----------------------------------------------------------------------------
// quad_motor_mix_limiter_top
// Plus-frame motor mixer with per-motor clamping and throttle limiting.
// ----------------------------------------------------------------------------
// Takes one throttle/roll/pitch/yaw command per cycle while the output does
// not stall and returns the four motor pulse widths through the five
// register stages: mix, clamp, min/max, throttle trim, sum and saturate,
// the last being the output register. A stall on the output freezes only
// the stages that are full, so bubbles are squeezed out. The idle, floor and
// ceiling levels are written through the configuration port (index 0, 1, 2;
// index 3 is ignored) and must only change while no command is in flight.
// ----------------------------------------------------------------------------
module quad_motor_mix_limiter_top import qmml_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// command channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [THR_W-1:0]  throttle,
	input  logic signed [CMD_W-1:0]  roll,
	input  logic signed [CMD_W-1:0]  pitch,
	input  logic signed [CMD_W-1:0]  yaw,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [PULSE_W-1:0]       front_drive,
	output logic [PULSE_W-1:0]       left_drive,
	output logic [PULSE_W-1:0]       back_drive,
	output logic [PULSE_W-1:0]       right_drive,
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [PULSE_W-1:0]       cfg_data
);

	levels_t lvl_q;
	logic    mix_vld, mix_rdy, lim_vld, lim_rdy, mix_in_rdy;
	mix_t    mix_data;
	lim_t    lim_data;

	// Register writes always complete in one transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q.idle      <= IDLE_RST;
			lvl_q.floor_lvl <= FLOOR_RST;
			lvl_q.ceil_lvl  <= CEILING_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IDLE:    lvl_q.idle      <= cfg_data;
				REG_FLOOR:   lvl_q.floor_lvl <= cfg_data;
				REG_CEILING: lvl_q.ceil_lvl  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = !mix_in_rdy;

	qmml_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (in_valid),
		.in_rdy   (mix_in_rdy),
		.throttle (throttle),
		.roll     (roll),
		.pitch    (pitch),
		.yaw      (yaw),
		.idle     (lvl_q.idle),
		.out_vld  (mix_vld),
		.out_rdy  (mix_rdy),
		.out_data (mix_data)
	);

	qmml_limit u_limit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (mix_vld),
		.in_rdy    (mix_rdy),
		.in_data   (mix_data),
		.floor_lvl (lvl_q.floor_lvl),
		.ceil_lvl  (lvl_q.ceil_lvl),
		.out_vld   (lim_vld),
		.out_rdy   (lim_rdy),
		.out_data  (lim_data)
	);

	qmml_trim u_trim (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (lim_vld),
		.in_rdy      (lim_rdy),
		.in_data     (lim_data),
		.floor_lvl   (lvl_q.floor_lvl),
		.ceil_lvl    (lvl_q.ceil_lvl),
		.out_vld     (out_valid),
		.out_rdy     (!out_stall),
		.front_drive (front_drive),
		.left_drive  (left_drive),
		.back_drive  (back_drive),
		.right_drive (right_drive)
	);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the plus-frame motor mixer and limiter. Commands
// are pushed through the block under several level settings and idle/stall
// patterns; a scoreboard predicts the four drives of each accepted command
// and compares them, in order, with the drives the block returns.
// ----------------------------------------------------------------------------
module testbench;
	import qmml_pkg::*;

	typedef logic signed [CMD_W-1:0]   cmd_t;
	typedef logic signed [SUM_W-1:0]   wide_t;
	typedef pulse_t [NUM_MOT-1:0]      drive_set_t;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 144;
	localparam int SETTLE_CYCLES   = 16;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int REPORT_LIMIT    = 10;
	localparam string MOTOR_NAME [NUM_MOT] = '{"front", "left", "back", "right"};

	// Predicts and checks the drives for each accepted command
	class motor_mix_board;
		pulse_t     idle_lvl;
		pulse_t     floor_lvl;
		pulse_t     ceil_lvl;
		drive_set_t expected_drives [$];
		int         errors;

		function new();
			idle_lvl  = IDLE_RST;
			floor_lvl = FLOOR_RST;
			ceil_lvl  = CEILING_RST;
			errors    = 0;
		endfunction

		function void note_level(logic [CFG_IDX_W-1:0] idx, pulse_t data);
			case (idx)
				REG_IDLE:    idle_lvl  = data;
				REG_FLOOR:   floor_lvl = data;
				REG_CEILING: ceil_lvl  = data;
				default: ;
			endcase
		endfunction

		function drive_set_t mix_and_limit(thr_t thr, cmd_t rl, cmd_t pt, cmd_t yw);
			wide_t      base;
			wide_t      flr;
			wide_t      ceil;
			wide_t      lo;
			wide_t      hi;
			wide_t      trim;
			wide_t      total;
			wide_t      raw [NUM_MOT];
			wide_t      held [NUM_MOT];
			drive_set_t drv;
			base = wide_t'(idle_lvl);
			flr  = wide_t'(floor_lvl);
			ceil = wide_t'(ceil_lvl);
			// mix around the idle level
			raw[MOT_FRONT] = base + wide_t'(pt) - wide_t'(yw);
			raw[MOT_LEFT]  = base + wide_t'(rl) + wide_t'(yw);
			raw[MOT_BACK]  = base - wide_t'(pt) - wide_t'(yw);
			raw[MOT_RIGHT] = base - wide_t'(rl) + wide_t'(yw);
			// clamp each motor, floor tested first
			for (int i = 0; i < NUM_MOT; i++) begin
				if (raw[i] < flr)
					held[i] = flr;
				else if (raw[i] > ceil)
					held[i] = ceil;
				else
					held[i] = raw[i];
			end
			lo = held[0];
			hi = held[0];
			for (int i = 1; i < NUM_MOT; i++) begin
				if (held[i] < lo)
					lo = held[i];
				if (held[i] > hi)
					hi = held[i];
			end
			// trim the throttle against the motor spread
			trim = wide_t'(thr);
			if (lo + trim < flr)
				trim = flr - lo;
			else if (hi + trim > ceil)
				trim = ceil - hi;
			// add and saturate to the pulse range
			for (int i = 0; i < NUM_MOT; i++) begin
				total = held[i] + trim;
				if (total < 0)
					drv[i] = '0;
				else if (total > wide_t'(PULSE_MAX))
					drv[i] = PULSE_MAX;
				else
					drv[i] = total[PULSE_W-1:0];
			end
			return drv;
		endfunction

		function void note_command(thr_t thr, cmd_t rl, cmd_t pt, cmd_t yw);
			expected_drives.push_back(mix_and_limit(thr, rl, pt, yw));
		endfunction

		function void check_drives(drive_set_t seen);
			drive_set_t want;
			if (expected_drives.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("ERROR: drive transfer with none expected: %p", seen);
			end else begin
				want = expected_drives.pop_front();
				for (int i = 0; i < NUM_MOT; i++) begin
					if (want[i] !== seen[i]) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("ERROR: %s drive expected %0d got %0d",
								MOTOR_NAME[i], want[i], seen[i]);
					end
				end
			end
		endfunction

		function void flag_leftovers();
			while (expected_drives.size() != 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("ERROR: drive set never returned: %p",
						expected_drives.pop_front());
				else
					void'(expected_drives.pop_front());
			end
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	thr_t                 throttle = '0;
	cmd_t                 roll = '0;
	cmd_t                 pitch = '0;
	cmd_t                 yaw = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	pulse_t               front_drive;
	pulse_t               left_drive;
	pulse_t               back_drive;
	pulse_t               right_drive;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	pulse_t               cfg_data = '0;

	int             send_gap_pct = 0;
	int             stall_pct = 0;
	int             cycle_count = 0;
	motor_mix_board board;

	quad_motor_mix_limiter_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.throttle    (throttle),
		.roll        (roll),
		.pitch       (pitch),
		.yaw         (yaw),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.front_drive (front_drive),
		.left_drive  (left_drive),
		.back_drive  (back_drive),
		.right_drive (right_drive),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Check each drive transfer and stall the result side at random
	always @(posedge clk) begin
		drive_set_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen[MOT_FRONT] = front_drive;
			seen[MOT_LEFT]  = left_drive;
			seen[MOT_BACK]  = back_drive;
			seen[MOT_RIGHT] = right_drive;
			board.check_drives(seen);
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycle_count);
			$display("quad_motor_mix_limiter_top regression: fail");
			$finish;
		end
	end

	// Offer one command, with random idle cycles ahead, and wait for its transfer
	task automatic send_command(input int thr, input int rl, input int pt, input int yw);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		throttle <= thr_t'(thr);
		roll     <= cmd_t'(rl);
		pitch    <= cmd_t'(pt);
		yaw      <= cmd_t'(yw);
		do @(posedge clk); while (in_stall);
		board.note_command(thr_t'(thr), cmd_t'(rl), cmd_t'(pt), cmd_t'(yw));
	endtask

	// Mostly commands near hover, some moderate, some over the full field range
	task automatic send_random_command();
		int mode;
		mode = $urandom_range(9);
		if (mode < 6)
			send_command(int'($urandom_range(1200)) - 600, int'($urandom_range(600)) - 300,
				int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300);
		else if (mode < 8)
			send_command(int'($urandom_range(5000)) - 2500, int'($urandom_range(2000)) - 1000,
				int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000);
		else
			send_command($urandom, $urandom, $urandom, $urandom);
	endtask

	// Drop valid and wait for every expected drive set
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input pulse_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		board.note_level(idx, data);
	endtask

	// Write all levels; the spare index is poked too and must be ignored
	task automatic program_levels(input pulse_t idle, input pulse_t flr, input pulse_t ceil);
		write_level(REG_SPARE, pulse_t'($urandom));
		write_level(REG_IDLE, idle);
		write_level(REG_FLOOR, flr);
		write_level(REG_CEILING, ceil);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		pulse_t flr;
		pulse_t ceil;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset levels: neutral, field extremes, each throttle trim branch
		send_command(0, 0, 0, 0);
		send_command(4095, 0, 0, 0);
		send_command(-4096, 0, 0, 0);
		send_command(-4096, -2048, -2048, -2048);
		send_command(4095, 2047, 2047, 2047);
		send_command(0, 2047, -2048, 0);
		send_command(0, -2048, 2047, 0);
		send_command(0, 0, 0, 2047);
		send_command(0, 0, 0, -2048);
		send_command(300, 200, -150, 100);
		send_command(-50, 400, 0, 0);
		send_command(600, 400, 0, 0);
		hold_until_drained();

		// Floor above ceiling
		program_levels(12'd2000, 12'd3000, 12'd1200);
		send_command(0, 0, 0, 0);
		send_command(-4096, 1500, -700, 300);
		send_command(4095, -2048, 2047, -2048);
		hold_until_drained();

		// Widest crossing: sums saturate at the pulse range
		program_levels(12'd2048, 12'd4095, 12'd0);
		send_command(4095, 0, 0, 0);
		send_command(-4096, 2047, -2048, 2047);
		send_command(0, -2048, 2047, 1000);
		hold_until_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 45; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 45; end
				default: begin send_gap_pct = 34; stall_pct = 34; end
			endcase
			flr  = pulse_t'($urandom);
			ceil = pulse_t'($urandom);
			case (phase)
				0: program_levels(IDLE_RST, FLOOR_RST, CEILING_RST);
				1: program_levels(12'd0, 12'd0, 12'd4095);
				2: program_levels(12'd4095, 12'd4095, 12'd4095);
				3: program_levels(12'd0, 12'd0, 12'd0);
				4, 5: begin
					if (flr > ceil)
						program_levels(pulse_t'($urandom), ceil, flr);
					else
						program_levels(pulse_t'($urandom), flr, ceil);
				end
				default: program_levels(pulse_t'($urandom), flr, ceil);
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					hold_until_drained();
				send_random_command();
			end
			hold_until_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		board.flag_leftovers();
		if (board.errors == 0)
			$display("quad_motor_mix_limiter_top regression: pass");
		else
			$display("quad_motor_mix_limiter_top regression: fail");
		$finish;
	end

endmodule
